FILE: hw/rtl/alvt_pkg.sv
// ----------------------------------------------------------------------------
// alvt_pkg: shared definitions for the LRU victim table
// Sizes, operation codes, metadata and compare-unit types used by every
// module of the victim table.
// ----------------------------------------------------------------------------
package alvt_pkg;

  // Table geometry.
  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [31:0] SLOTS_U32 = 32'(SLOTS);

  // The timestamp is refreshed on every UPDATE_INTERVAL-th touch.
  // The interval is a power of two, so the multiple test is a mask.
  localparam int UI_LOG2 = 4;
  localparam int UPDATE_INTERVAL = 1 << UI_LOG2;
  localparam logic [31:0] UI_MASK = 32'(UPDATE_INTERVAL - 1);

  // Timestamp value that the search starts from.
  localparam logic [31:0] TS_NONE = 32'hFFFF_FFFF;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] KIND_INSTALL = 2'd0;
  localparam logic [1:0] KIND_TOUCH   = 2'd1;
  localparam logic [1:0] KIND_FIND    = 2'd2;
  localparam logic [1:0] KIND_EVICT   = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TOUCH = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // One metadata entry of the table memory.
  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] ts;
  } meta_t;

  // One scanned entry presented to the compare unit.
  typedef struct packed {
    logic              vld;
    logic              pres;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       ts;
    logic [31:0]       cnt;
  } cmp_in_t;

  // Current winner of the search.
  typedef struct packed {
    logic              have;
    logic [SLOT_W-1:0] idx;
  } cmp_res_t;

endpackage

FILE: hw/rtl/alvt_meta_ram.sv
// ----------------------------------------------------------------------------
// alvt_meta_ram: metadata memory of the victim table
// One write port and one read port with registered read data, holding the
// use count and last-use timestamp of every slot.
// ----------------------------------------------------------------------------
module alvt_meta_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [alvt_pkg::SLOT_W-1:0] wr_addr,
  input  alvt_pkg::meta_t            wr_data,
  input  logic [alvt_pkg::SLOT_W-1:0] rd_addr,
  output alvt_pkg::meta_t            rd_data
);

  alvt_pkg::meta_t mem [alvt_pkg::SLOTS];
  alvt_pkg::meta_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/alvt_scan_cmp.sv
// ----------------------------------------------------------------------------
// alvt_scan_cmp: compare unit for the victim search
// Takes one scanned entry per cycle and keeps the entry with the smallest
// timestamp, ties going to the smaller use count and then the earlier slot.
// ----------------------------------------------------------------------------
module alvt_scan_cmp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  alvt_pkg::cmp_in_t   cand,
  output alvt_pkg::cmp_res_t  res
);

  logic                        have_r, have_nxt;
  logic [alvt_pkg::SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]                 best_ts_r, best_ts_nxt;
  logic [31:0]                 best_cnt_r, best_cnt_nxt;
  logic                        ts_less;
  logic                        tie_win;
  logic                        take;

  // A strictly older timestamp always wins; an equal one wins only on a
  // smaller use count once a candidate exists.
  always_comb begin
    ts_less = cand.ts < best_ts_r;
    tie_win = have_r && (cand.ts == best_ts_r) && (cand.cnt < best_cnt_r);
    take    = cand.vld && cand.pres && (ts_less || tie_win);
  end

  // Next winner.
  always_comb begin
    have_nxt     = have_r;
    best_idx_nxt = best_idx_r;
    best_ts_nxt  = best_ts_r;
    best_cnt_nxt = best_cnt_r;
    if (start) begin
      have_nxt     = 1'b0;
      best_idx_nxt = '0;
      best_ts_nxt  = alvt_pkg::TS_NONE;
      best_cnt_nxt = '0;
    end else if (take) begin
      have_nxt     = 1'b1;
      best_idx_nxt = cand.idx;
      best_ts_nxt  = cand.ts;
      best_cnt_nxt = cand.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_ts_r  <= best_ts_nxt;
    best_cnt_r <= best_cnt_nxt;
  end

  assign res.have = have_r;
  assign res.idx  = best_idx_r;

endmodule

FILE: hw/rtl/amortized_lru_victim_table_unit.sv
// ----------------------------------------------------------------------------
// amortized_lru_victim_table_unit: LRU victim table with amortised timestamps
// Tracks present slots with a use count and last-use time, and finds the
// least recently used slot by scanning the table.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation and produces exactly one result
// transfer. Install, evict and a touch of an empty slot are answered in the
// cycle after the transfer; a touch of a present slot first passes S_TOUCH
// for the read-modify-write of its metadata. A find walks the metadata
// memory through its single read port, one slot per cycle, then passes
// S_DRAIN and S_FIN before the result is presented. The input is not ready
// while an operation is in progress or a result waits to be taken. Metadata
// memory contents are not cleared at reset; only the present flags are.
module amortized_lru_victim_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] slot, [37:6] timestamp, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] found, [6:1] victim, [7] status
);

  alvt_pkg::state_t      state_r, state_nxt;
  logic [alvt_pkg::SLOTS-1:0] present_r, present_nxt;
  logic [alvt_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [31:0]           ts_r, ts_nxt;
  logic [alvt_pkg::SLOT_W-1:0] rd_addr_r, rd_addr_nxt;
  logic                  pipe_vld_r, pipe_vld_nxt;
  logic [alvt_pkg::SLOT_W-1:0] pipe_idx_r, pipe_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [5:0]            out_victim_r, out_victim_nxt;
  logic                  out_status_r, out_status_nxt;

  logic                  in_acc;
  logic [1:0]            in_kind;
  logic [5:0]            in_slot;
  logic [31:0]           in_ts;
  logic [alvt_pkg::SLOT_W-1:0] in_idx;
  logic                  in_range;
  logic                  in_hit;

  logic                  ram_wr_en;
  logic [alvt_pkg::SLOT_W-1:0] ram_wr_addr;
  alvt_pkg::meta_t       ram_wr_data;
  logic [alvt_pkg::SLOT_W-1:0] ram_rd_addr;
  alvt_pkg::meta_t       ram_rd_data;
  logic [31:0]           cnt_inc;

  logic                  cmp_start;
  alvt_pkg::cmp_in_t     cmp_in;
  alvt_pkg::cmp_res_t    cmp_res;

  // Field unpacking and slot decoding.
  always_comb begin
    in_kind  = in_tuser;
    in_slot  = in_tdata[5:0];
    in_ts    = in_tdata[37:6];
    in_idx   = alvt_pkg::SLOT_W'(in_slot);
    in_range = 32'(in_slot) < alvt_pkg::SLOTS_U32;
    in_hit   = in_range && present_r[in_idx];
    in_acc   = in_tvalid && in_tready;
    cnt_inc  = ram_rd_data.cnt + 32'd1;
  end

  assign in_tready = (state_r == alvt_pkg::S_IDLE) && !out_valid_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    present_nxt    = present_r;
    slot_nxt       = slot_r;
    ts_nxt         = ts_r;
    rd_addr_nxt    = rd_addr_r;
    pipe_vld_nxt   = 1'b0;
    pipe_idx_nxt   = rd_addr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_victim_nxt = out_victim_r;
    out_status_nxt = out_status_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = in_idx;
    ram_wr_data    = '{cnt: 32'd0, ts: in_ts};
    ram_rd_addr    = in_idx;
    cmp_start      = 1'b0;

    unique case (state_r)
      alvt_pkg::S_IDLE: begin
        if (in_acc) begin
          slot_nxt       = in_idx;
          ts_nxt         = in_ts;
          out_found_nxt  = 1'b0;
          out_victim_nxt = 6'd0;
          out_status_nxt = 1'b0;
          unique case (in_kind)
            alvt_pkg::KIND_INSTALL: begin
              if (in_range) begin
                present_nxt[in_idx] = 1'b1;
                ram_wr_en           = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            alvt_pkg::KIND_TOUCH: begin
              if (in_hit) begin
                state_nxt = alvt_pkg::S_TOUCH;
              end else begin
                out_status_nxt = 1'b1;
                out_valid_nxt  = 1'b1;
              end
            end
            alvt_pkg::KIND_FIND: begin
              cmp_start   = 1'b1;
              rd_addr_nxt = '0;
              state_nxt   = alvt_pkg::S_SCAN;
            end
            alvt_pkg::KIND_EVICT: begin
              if (in_hit) begin
                present_nxt[in_idx] = 1'b0;
              end else begin
                out_status_nxt = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              state_nxt = alvt_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Metadata of the touched slot is on the read port now.
      alvt_pkg::S_TOUCH: begin
        ram_wr_en        = 1'b1;
        ram_wr_addr      = slot_r;
        ram_wr_data.cnt  = cnt_inc;
        ram_wr_data.ts   = ((cnt_inc & alvt_pkg::UI_MASK) == 32'd0) ? ts_r
                                                                     : ram_rd_data.ts;
        out_valid_nxt    = 1'b1;
        state_nxt        = alvt_pkg::S_IDLE;
      end

      // Issue one read per cycle; each entry reaches the compare in the cycle after its read.
      alvt_pkg::S_SCAN: begin
        ram_rd_addr  = rd_addr_r;
        rd_addr_nxt  = rd_addr_r + alvt_pkg::SLOT_W'(1);
        pipe_vld_nxt = 1'b1;
        if (rd_addr_r == alvt_pkg::SLOT_LAST) begin
          state_nxt = alvt_pkg::S_DRAIN;
        end
      end

      // Last entry is being compared.
      alvt_pkg::S_DRAIN: begin
        state_nxt = alvt_pkg::S_FIN;
      end

      alvt_pkg::S_FIN: begin
        out_found_nxt  = cmp_res.have;
        out_victim_nxt = cmp_res.have ? 6'(cmp_res.idx) : 6'd0;
        out_status_nxt = 1'b0;
        out_valid_nxt  = 1'b1;
        state_nxt      = alvt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = alvt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alvt_pkg::S_IDLE;
      present_r   <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    ts_r         <= ts_nxt;
    rd_addr_r    <= rd_addr_nxt;
    pipe_idx_r   <= pipe_idx_nxt;
    out_found_r  <= out_found_nxt;
    out_victim_r <= out_victim_nxt;
    out_status_r <= out_status_nxt;
  end

  // Scanned entry as seen by the compare unit.
  always_comb begin
    cmp_in.vld  = pipe_vld_r;
    cmp_in.pres = present_r[pipe_idx_r];
    cmp_in.idx  = pipe_idx_r;
    cmp_in.ts   = ram_rd_data.ts;
    cmp_in.cnt  = ram_rd_data.cnt;
  end

  alvt_meta_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  alvt_scan_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .cand  (cmp_in),
    .res   (cmp_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, out_victim_r, out_found_r};

endmodule

FILE: hw/rtl/alvt_checker.sv
// ----------------------------------------------------------------------------
// alvt_checker: port-level checks for the LRU victim table
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module alvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // The block is not ready in the cycle after it takes an operation.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transfer");

  // No new operation is taken while a result is still waiting.
  a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Without a victim the victim field reads zero.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[6:1] == 6'd0)
    else $error("victim set without a find hit");

  // A found victim never comes with a set status.
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[7])
    else $error("found and status both set");

endmodule

bind amortized_lru_victim_table_unit alvt_checker u_alvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU victim table
// A short table of directed operations covers the empty table, the all-ones
// timestamp, full ties, reinstalls and misses on empty slots. Random traffic
// with hot slot sets follows, deep enough to reach the interval timestamp
// refresh. Every answer is checked against a typed-in answer or a local model.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS  = 700;
  localparam int DIRECTED_ROWS = 23;
  localparam int STALL_PERCENT = 32;

  // One answer of the table; its fields are checked one by one against out_tdata.
  typedef struct packed {
    logic                        found;
    logic [alvt_pkg::SLOT_W-1:0] victim;
    logic                        status;
  } answer_t;

  // One directed operation; the answer is typed in where it is obvious.
  typedef struct {
    logic [1:0]                  kind;
    logic [alvt_pkg::SLOT_W-1:0] slot;
    logic [31:0]                 stamp;
    bit                          typed;
    logic                        ex_found;
    logic [alvt_pkg::SLOT_W-1:0] ex_victim;
    logic                        ex_status;
  } step_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [39:0]       in_tdata;   // [5:0] slot, [37:6] timestamp, [39:38] zero
  logic [1:0]        in_tuser;   // [1:0] kind
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // [0] found, [6:1] victim, [7] status

  // Local copy of the table contents.
  bit                tab_present [alvt_pkg::SLOTS];
  logic [31:0]       tab_count   [alvt_pkg::SLOTS];
  logic [31:0]       tab_stamp   [alvt_pkg::SLOTS];

  answer_t           expected_answers [$];
  int                mismatches;
  bit                steady;
  step_row_t         script [DIRECTED_ROWS];

  amortized_lru_victim_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Applies one operation to the local table and returns its answer.
  function automatic answer_t compute_answer(input logic [1:0] kind,
                                             input logic [alvt_pkg::SLOT_W-1:0] slot,
                                             input logic [31:0] stamp);
    answer_t     res;
    logic [31:0] bumped;
    logic [31:0] best_stamp;
    int          best;
    bit          have;
    bit          in_range;
    res        = '0;
    in_range   = int'(slot) < alvt_pkg::SLOTS;
    best_stamp = alvt_pkg::TS_NONE;
    best       = 0;
    have       = 1'b0;
    case (kind)
      alvt_pkg::KIND_INSTALL: begin
        if (in_range) begin
          tab_present[slot] = 1'b1;
          tab_count[slot]   = 32'd0;
          tab_stamp[slot]   = stamp;
        end
      end
      alvt_pkg::KIND_TOUCH: begin
        if (in_range && tab_present[slot]) begin
          bumped          = tab_count[slot] + 32'd1;
          tab_count[slot] = bumped;
          // The timestamp only moves on every interval-th touch.
          if ((bumped % 32'(alvt_pkg::UPDATE_INTERVAL)) == 32'd0) begin
            tab_stamp[slot] = stamp;
          end
        end else begin
          res.status = 1'b1;
        end
      end
      alvt_pkg::KIND_FIND: begin
        // A strictly older stamp takes over; equal stamps go to the lower count.
        for (int i = 0; i < alvt_pkg::SLOTS; i++) begin
          if (tab_present[i]) begin
            if (tab_stamp[i] < best_stamp) begin
              best_stamp = tab_stamp[i];
              best       = i;
              have       = 1'b1;
            end else if (have && tab_stamp[i] == best_stamp &&
                         tab_count[i] < tab_count[best]) begin
              best = i;
            end
          end
        end
        res.found  = have;
        res.victim = have ? alvt_pkg::SLOT_W'(best) : '0;
      end
      default: begin
        if (in_range && tab_present[slot]) begin
          tab_present[slot] = 1'b0;
        end else begin
          res.status = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  // Offers one operation, waits for its transfer and predicts the answer.
  task automatic offer_op(input logic [1:0] kind,
                          input logic [alvt_pkg::SLOT_W-1:0] slot,
                          input logic [31:0] stamp, output answer_t predicted);
    while (!steady && $urandom_range(0, 99) < STALL_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, stamp, slot};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    predicted = compute_answer(kind, slot, stamp);
  endtask

  // Holds the input idle until every outstanding answer has arrived.
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
               want, got);
      mismatches++;
    end
  endtask

  // Stimulus: directed table, then random traffic around hot slot sets.
  initial begin
    answer_t                     predicted;
    answer_t                     typed_answer;
    int                          r;
    int                          hot_base;
    int                          hot_span;
    int                          warm;
    bit                          touchy;
    logic [31:0]                 now;
    logic [1:0]                  kind;
    logic [alvt_pkg::SLOT_W-1:0] slot;
    logic [31:0]                 stamp;

    script = '{
      // Empty table, misses on empty slots.
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_TOUCH,   6'd5,  32'h1234_5678, 1'b1, 1'b0, 6'd0,  1'b1},
      '{alvt_pkg::KIND_EVICT,   6'd63, 32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b1},
      // A slot stamped all ones is never chosen.
      '{alvt_pkg::KIND_INSTALL, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_TOUCH,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_INSTALL, 6'd63, 32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b1, 1'b1, 6'd63, 1'b0},
      // A full tie goes to the earlier slot.
      '{alvt_pkg::KIND_INSTALL, 6'd10, 32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b1, 1'b1, 6'd10, 1'b0},
      // A tie on the stamp goes to the lower count.
      '{alvt_pkg::KIND_TOUCH,   6'd10, 32'h0000_0007, 1'b0, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0,  1'b0},
      // Reinstall of a present slot.
      '{alvt_pkg::KIND_INSTALL, 6'd63, 32'h8000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_INSTALL, 6'd42, 32'hFFFF_FFFE, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_EVICT,   6'd10, 32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_EVICT,   6'd10, 32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b1},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_EVICT,   6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd63, 32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_TOUCH,   6'd63, 32'hAAAA_AAAA, 1'b1, 1'b0, 6'd0,  1'b1},
      '{alvt_pkg::KIND_INSTALL, 6'd1,  32'h5555_5555, 1'b1, 1'b0, 6'd0,  1'b0},
      '{alvt_pkg::KIND_FIND,    6'd0,  32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0}
    };

    for (int i = 0; i < alvt_pkg::SLOTS; i++) begin
      tab_present[i] = 1'b0;
      tab_count[i]   = 32'd0;
      tab_stamp[i]   = 32'd0;
    end
    mismatches = 0;
    steady     = 1'b0;
    now        = 32'd0;
    hot_base   = 0;
    hot_span   = 1;
    warm       = 0;
    touchy     = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= alvt_pkg::KIND_INSTALL;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_op(script[i].kind, script[i].slot, script[i].stamp, predicted);
      typed_answer.found  = script[i].ex_found;
      typed_answer.victim = script[i].ex_victim;
      typed_answer.status = script[i].ex_status;
      expected_answers.push_back(script[i].typed ? typed_answer : predicted);
    end

    // Random traffic in phases; touch-heavy phases reach the stamp refresh.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        touchy   = ($urandom_range(0, 99) < 45);
        hot_base = $urandom_range(0, alvt_pkg::SLOTS - 1);
        hot_span = touchy ? $urandom_range(1, 2) : $urandom_range(2, 8);
        warm     = hot_span;
        if ($urandom_range(0, 99) < 20) begin
          now = 32'hFFFF_FF00;
        end
      end
      steady = (n >= 300 && n < 400);
      if (n == 450) begin
        drain_answers();
      end

      now = now + 32'($urandom_range(0, 3));
      r   = $urandom_range(0, 99);
      if (r < 65) begin
        stamp = now;
      end else if (r < 77) begin
        stamp = $urandom;
      end else if (r < 87) begin
        stamp = 32'($urandom_range(0, 3));
      end else if (r < 94) begin
        stamp = alvt_pkg::TS_NONE;
      end else begin
        stamp = alvt_pkg::TS_NONE - 32'($urandom_range(1, 3));
      end

      if (warm > 0) begin
        // Fill the hot set first so that later touches land on present slots.
        kind = alvt_pkg::KIND_INSTALL;
        slot = alvt_pkg::SLOT_W'((hot_base + hot_span - warm) % alvt_pkg::SLOTS);
        warm--;
      end else begin
        if ($urandom_range(0, 99) < 85) begin
          slot = alvt_pkg::SLOT_W'((hot_base + $urandom_range(0, hot_span - 1)) %
                                   alvt_pkg::SLOTS);
        end else begin
          slot = alvt_pkg::SLOT_W'($urandom_range(0, alvt_pkg::SLOTS - 1));
        end
        r = $urandom_range(0, 99);
        if (touchy) begin
          kind = (r < 4)  ? alvt_pkg::KIND_INSTALL :
                 (r < 88) ? alvt_pkg::KIND_TOUCH :
                 (r < 96) ? alvt_pkg::KIND_FIND : alvt_pkg::KIND_EVICT;
        end else begin
          kind = (r < 25) ? alvt_pkg::KIND_INSTALL :
                 (r < 55) ? alvt_pkg::KIND_TOUCH :
                 (r < 75) ? alvt_pkg::KIND_FIND : alvt_pkg::KIND_EVICT;
        end
      end
      offer_op(kind, slot, stamp, predicted);
      expected_answers.push_back(predicted);
    end
    steady = 1'b0;

    // Wait for the last answers, then allow for a late find to show up.
    drain_answers();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: check each transfer and pace out_tready.
  initial begin
    answer_t want;
    int      answers_seen;
    int      hold_left;
    bit      held;
    answers_seen = 0;
    hold_left    = 0;
    held         = 1'b0;
    out_tready   <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: answer without a pending operation, actual %0h",
                   $realtime, out_tdata);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          check_field("found",  want.found,  out_tdata[0]);
          check_field("victim", want.victim, out_tdata[alvt_pkg::SLOT_W:1]);
          check_field("status", want.status, out_tdata[7]);
        end
        answers_seen++;
      end
      // One long hold-off lets the input back up behind a waiting answer.
      if (!held && answers_seen >= 250) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= STALL_PERCENT);
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
